// ===== hdl/bcs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bezier curve sampler package
// Widths, beat types and the binomial coefficient table of the sampler.
// ----------------------------------------------------------------------------
package bcs_pkg;

	localparam int MAX_POINTS  = 8;
	localparam int COORD_WIDTH = 16;
	localparam int SEG_WIDTH   = 6;

	localparam int Q_FRAC      = 16;
	localparam int FRAC_WIDTH  = Q_FRAC + 1;
	localparam int IDX_WIDTH   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CNT_WIDTH   = $clog2(MAX_POINTS + 1);
	localparam int DIV_CNT_WIDTH = $clog2(FRAC_WIDTH);

	function automatic int max_binom();
		int row [MAX_POINTS];
		int best;
		best = 1;
		for (int k = 0; k < MAX_POINTS; k++) begin
			row[k] = 0;
		end
		for (int n = 0; n < MAX_POINTS; n++) begin
			for (int k = n; k > 0; k--) begin
				row[k] = row[k] + row[k - 1];
			end
			row[0] = 1;
			for (int k = 0; k <= n; k++) begin
				if (row[k] > best) begin
					best = row[k];
				end
			end
		end
		return best;
	endfunction

	localparam int BINOM_WIDTH = $clog2(max_binom() + 1);

	localparam int MUL_A_WIDTH = FRAC_WIDTH + 1;
	localparam int MUL_B_WIDTH = (COORD_WIDTH + BINOM_WIDTH + 1 > FRAC_WIDTH + 1) ?
		COORD_WIDTH + BINOM_WIDTH + 1 : FRAC_WIDTH + 1;
	localparam int MUL_WIDTH   = MUL_A_WIDTH + MUL_B_WIDTH;
	localparam int ACC_WIDTH   = MUL_WIDTH + IDX_WIDTH;

	typedef logic [MAX_POINTS-1:0][MAX_POINTS-1:0][BINOM_WIDTH-1:0] binom_table_t;

	function automatic binom_table_t build_binom();
		binom_table_t tbl;
		int row [MAX_POINTS];
		tbl = '0;
		for (int k = 0; k < MAX_POINTS; k++) begin
			row[k] = 0;
		end
		for (int n = 0; n < MAX_POINTS; n++) begin
			for (int k = n; k > 0; k--) begin
				row[k] = row[k] + row[k - 1];
			end
			row[0] = 1;
			for (int k = 0; k <= n; k++) begin
				tbl[n][k] = BINOM_WIDTH'(row[k]);
			end
		end
		return tbl;
	endfunction

	localparam binom_table_t BINOM = build_binom();

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] point_x;
		logic signed [COORD_WIDTH-1:0] point_y;
		logic                          last_point;
	} point_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] curve_x;
		logic signed [COORD_WIDTH-1:0] curve_y;
		logic [SEG_WIDTH-1:0]          sample_index;
		logic                          last_sample;
		logic                          points_dropped;
	} sample_t;

endpackage

// ===== hdl/bezier_curve_sampler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bezier curve sampler
// Stores 2D control points and samples the Bernstein form of the curve.
// ----------------------------------------------------------------------------
// Control points enter on the point port, one beat per cycle at most, taken
// when start is high and busy is low. A point without last_point is stored
// and causes no sample. A point with last_point closes the curve: busy rises
// and the block emits segment_count+1 samples (two if it is 0), each shown
// for exactly one cycle with sample_valid high. The receiver cannot stall.
// Points beyond the store depth are dropped and reported on every sample.
// The segment_count register is written on the cfg port while busy is low.
//
// The reciprocal of segment_count is found by a restoring division when the
// curve closes. Each sample is then a sum of deg+1 terms, where deg is the
// number of stored points minus one, all computed on the single shared
// multiplier. Busy falls in the cycle that shows the last sample.
//
// Reset clears the point store count, the drop flag and the handshake, and
// sets segment_count to 16.
// ----------------------------------------------------------------------------
module bezier_curve_sampler
	import bcs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  point_t               point,
	output logic                 sample_valid,
	output sample_t              sample,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [SEG_WIDTH-1:0] cfg_data
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DIV,
		S_TERM,
		S_MUL,
		S_RND,
		S_CX,
		S_PX,
		S_AX,
		S_PY,
		S_AY,
		S_OUT
	} state_t;

	localparam logic [FRAC_WIDTH-1:0] ONE_Q = FRAC_WIDTH'(1) << Q_FRAC;
	localparam logic signed [COORD_WIDTH-1:0] C_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [COORD_WIDTH-1:0] C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
	localparam int RW = ACC_WIDTH - Q_FRAC + 1;

	function automatic logic signed [COORD_WIDTH-1:0] round_sat(
		input logic signed [ACC_WIDTH-1:0] acc
	);
		logic signed [ACC_WIDTH:0] q;
		logic signed [RW-1:0]      r;
		q = (ACC_WIDTH+1)'(acc) + (ACC_WIDTH+1)'(ONE_Q >> 1);
		r = $signed(q[ACC_WIDTH:Q_FRAC]);
		if (r > RW'(C_MAX)) begin
			return C_MAX;
		end
		if (r < RW'(C_MIN)) begin
			return C_MIN;
		end
		return COORD_WIDTH'(r);
	endfunction

	state_t                 state_q;
	logic                   busy_q;
	logic                   sample_valid_q;
	sample_t                sample_q;
	logic [SEG_WIDTH-1:0]   seg_q;
	logic [CNT_WIDTH-1:0]   count_q;
	logic                   dropped_q;
	logic [IDX_WIDTH-1:0]   deg_q;
	logic [IDX_WIDTH-1:0]   j_q;
	logic [IDX_WIDTH-1:0]   k_q;
	logic [SEG_WIDTH-1:0]   i_q;
	logic [DIV_CNT_WIDTH-1:0] bitcnt_q;

	logic signed [COORD_WIDTH-1:0] store_x [MAX_POINTS];
	logic signed [COORD_WIDTH-1:0] store_y [MAX_POINTS];
	logic signed [COORD_WIDTH-1:0] pt_x_q;
	logic signed [COORD_WIDTH-1:0] pt_y_q;
	logic signed [MUL_WIDTH-1:0]   prod_q;
	logic [FRAC_WIDTH-1:0]         p_q;
	logic signed [ACC_WIDTH-1:0]   acc_x_q;
	logic signed [ACC_WIDTH-1:0]   acc_y_q;
	logic [FRAC_WIDTH-1:0]         t_q;
	logic [SEG_WIDTH-1:0]          trem_q;
	logic [FRAC_WIDTH-1:0]         q0_q;
	logic [SEG_WIDTH-1:0]          r0_q;

	logic                          accept;
	logic                          store_ok;
	logic [CNT_WIDTH-1:0]          count_next;
	logic [SEG_WIDTH-1:0]          seg_eff;
	logic [FRAC_WIDTH-1:0]         u_val;
	logic [FRAC_WIDTH-1:0]         factor;
	logic [BINOM_WIDTH-1:0]        coef;
	logic signed [MUL_A_WIDTH-1:0] mul_a;
	logic signed [MUL_B_WIDTH-1:0] mul_b;
	logic [SEG_WIDTH:0]            div_trial;
	logic                          div_take;
	logic [SEG_WIDTH:0]            tsum;
	logic                          t_carry;
	logic                          div_last;
	logic                          curve_end;

	always_comb begin
		accept     = start && !busy_q;
		store_ok   = count_q < CNT_WIDTH'(MAX_POINTS);
		count_next = store_ok ? count_q + CNT_WIDTH'(1) : count_q;
		seg_eff    = (seg_q == '0) ? SEG_WIDTH'(1) : seg_q;
		u_val      = ONE_Q - t_q;
		factor     = (({1'b0, k_q} + {1'b0, j_q}) < {1'b0, deg_q}) ? u_val : t_q;
		coef       = BINOM[deg_q][j_q];
		div_trial  = {r0_q, (bitcnt_q == '0)};
		div_take   = div_trial >= {1'b0, seg_eff};
		div_last   = bitcnt_q == DIV_CNT_WIDTH'(FRAC_WIDTH - 1);
		tsum       = {1'b0, trem_q} + {1'b0, r0_q};
		t_carry    = tsum >= {1'b0, seg_eff};
		curve_end  = i_q == seg_eff;
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_MUL: begin
				mul_a = MUL_A_WIDTH'(p_q);
				mul_b = MUL_B_WIDTH'(factor);
			end
			S_CX: begin
				mul_a = MUL_A_WIDTH'(coef);
				mul_b = MUL_B_WIDTH'(pt_x_q);
			end
			S_AX: begin
				mul_a = MUL_A_WIDTH'(coef);
				mul_b = MUL_B_WIDTH'(pt_y_q);
			end
			S_PX, S_PY: begin
				mul_a = MUL_A_WIDTH'(p_q);
				mul_b = $signed(prod_q[MUL_B_WIDTH-1:0]);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			busy_q         <= 1'b0;
			sample_valid_q <= 1'b0;
			sample_q       <= '0;
			seg_q          <= SEG_WIDTH'(16);
			count_q        <= '0;
			dropped_q      <= 1'b0;
			deg_q          <= '0;
			j_q            <= '0;
			k_q            <= '0;
			i_q            <= '0;
			bitcnt_q       <= '0;
		end else begin
			sample_valid_q <= 1'b0;
			if (cfg_valid && !busy_q) begin
				seg_q <= cfg_data;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						count_q   <= count_next;
						dropped_q <= dropped_q || !store_ok;
						if (point.last_point) begin
							deg_q    <= IDX_WIDTH'(count_next - CNT_WIDTH'(1));
							bitcnt_q <= '0;
							busy_q   <= 1'b1;
							state_q  <= S_DIV;
						end
					end
				end
				S_DIV: begin
					bitcnt_q <= bitcnt_q + DIV_CNT_WIDTH'(1);
					if (div_last) begin
						i_q     <= '0;
						j_q     <= '0;
						state_q <= S_TERM;
					end
				end
				S_TERM: begin
					k_q     <= '0;
					state_q <= (deg_q == '0) ? S_CX : S_MUL;
				end
				S_MUL: begin
					state_q <= S_RND;
				end
				S_RND: begin
					if (k_q == deg_q - IDX_WIDTH'(1)) begin
						state_q <= S_CX;
					end else begin
						k_q     <= k_q + IDX_WIDTH'(1);
						state_q <= S_MUL;
					end
				end
				S_CX: begin
					state_q <= S_PX;
				end
				S_PX: begin
					state_q <= S_AX;
				end
				S_AX: begin
					state_q <= S_PY;
				end
				S_PY: begin
					state_q <= S_AY;
				end
				S_AY: begin
					if (j_q == deg_q) begin
						state_q <= S_OUT;
					end else begin
						j_q     <= j_q + IDX_WIDTH'(1);
						state_q <= S_TERM;
					end
				end
				S_OUT: begin
					sample_valid_q          <= 1'b1;
					sample_q.curve_x        <= round_sat(acc_x_q);
					sample_q.curve_y        <= round_sat(acc_y_q);
					sample_q.sample_index   <= i_q;
					sample_q.last_sample    <= curve_end;
					sample_q.points_dropped <= dropped_q;
					if (curve_end) begin
						count_q   <= '0;
						dropped_q <= 1'b0;
						busy_q    <= 1'b0;
						state_q   <= S_IDLE;
					end else begin
						i_q     <= i_q + SEG_WIDTH'(1);
						j_q     <= '0;
						state_q <= S_TERM;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (state_q == S_IDLE && accept) begin
			if (store_ok) begin
				store_x[count_q[IDX_WIDTH-1:0]] <= point.point_x;
				store_y[count_q[IDX_WIDTH-1:0]] <= point.point_y;
			end
			r0_q <= '0;
			q0_q <= '0;
		end
		if (state_q == S_DIV) begin
			r0_q <= div_take ? SEG_WIDTH'(div_trial - {1'b0, seg_eff}) :
				SEG_WIDTH'(div_trial);
			q0_q <= {q0_q[FRAC_WIDTH-2:0], div_take};
			if (div_last) begin
				t_q     <= '0;
				trem_q  <= seg_eff >> 1;
				acc_x_q <= '0;
				acc_y_q <= '0;
			end
		end
		if (state_q == S_TERM) begin
			p_q    <= ONE_Q;
			pt_x_q <= store_x[j_q];
			pt_y_q <= store_y[j_q];
		end
		if (state_q == S_RND) begin
			p_q <= FRAC_WIDTH'((prod_q + MUL_WIDTH'(ONE_Q >> 1)) >>> Q_FRAC);
		end
		if (state_q == S_AX) begin
			acc_x_q <= acc_x_q + ACC_WIDTH'(prod_q);
		end
		if (state_q == S_AY) begin
			acc_y_q <= acc_y_q + ACC_WIDTH'(prod_q);
		end
		if (state_q == S_OUT) begin
			acc_x_q <= '0;
			acc_y_q <= '0;
			if (t_carry) begin
				trem_q <= SEG_WIDTH'(tsum - {1'b0, seg_eff});
				t_q    <= t_q + q0_q + FRAC_WIDTH'(1);
			end else begin
				trem_q <= SEG_WIDTH'(tsum);
				t_q    <= t_q + q0_q;
			end
		end
	end

	assign busy         = busy_q;
	assign sample_valid = sample_valid_q;
	assign sample       = sample_q;
	assign cfg_ready    = !busy_q;

	// The final sample of a curve carries the interval count and ends the busy period.
	a_last_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample.last_sample |-> !busy && sample.sample_index == seg_eff)
		else $error("last sample not aligned with end of curve");

	a_mid_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample.last_sample |-> busy)
		else $error("intermediate sample outside busy period");

	a_busy_falls_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> sample_valid && sample.last_sample)
		else $error("busy fell without a last sample");

	a_strobe_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid |=> !sample_valid)
		else $error("samples in adjacent cycles");

endmodule
